>>> sv/bsb_pkg.sv
// bsb_pkg: shared types, constants and helper functions of the bilinear sampler
// used by bsb_mac and bilinear_sample_with_border_top; no dependencies

package bsb_pkg;

    // default sizes handed to the top level parameters
    localparam int STORE_BYTES_DEF  = 65536;
    localparam int MAX_CHANNELS_DEF = 4;

    // fixed field widths
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 16;
    localparam int CNT_W    = 3;
    localparam int PIX_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROWMUL,
        S_COLMUL,
        S_ADDR,
        S_RD00,
        S_RD10,
        S_RD01,
        S_RD11,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_DONE
    } state_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctrl_t;

    // which neighbour lines lie inside: bit0 lower index, bit1 upper index
    function automatic logic [1:0] lines_taken(input logic signed [16:0] hi,
                                               input logic [DIM_W-1:0] dim);
        logic signed [17:0] h;
        logic signed [17:0] d;
        logic [1:0]         res;
        h = {hi[16], hi};
        d = {5'b0, dim};
        if (h > 18'sd0 && h < d)
            res = 2'b11;
        else if (h == 18'sd0)
            res = 2'b10;
        else if (h == d)
            res = 2'b01;
        else
            res = 2'b00;
        return res;
    endfunction

    // channels produced for a channel count
    function automatic logic [CNT_W-1:0] chan_limit(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        if (cnt == 3'd1)
            res = 3'd1;
        else if (cnt == 3'd3)
            res = 3'd3;
        else if (cnt >= 3'd4)
            res = 3'd4;
        else
            res = 3'd0;
        return res;
    endfunction

endpackage

>>> sv/bsb_ram.sv
// bsb_ram: generic single write port, single read port ram with registered read
// no dependencies

module bsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bsb_mac.sv
// bsb_mac: shared multiply-accumulate unit, one product a cycle while ctrl.en is high
// depends on bsb_pkg for the control struct

module bsb_mac #(
    parameter int A_W = 17,
    parameter int B_W = 16
) (
    input  logic                   clk,
    input  bsb_pkg::mac_ctrl_t     ctrl,
    input  logic [A_W-1:0]         a,
    input  logic [B_W-1:0]         b,
    output logic [A_W+B_W-1:0]     acc
);

    import bsb_pkg::*;

    logic [A_W+B_W-1:0] acc_reg;
    logic [A_W+B_W-1:0] acc_next;
    logic [A_W+B_W-1:0] prod;

    always_comb
    begin
        prod = (A_W+B_W)'(a) * (A_W+B_W)'(b);
        if (ctrl.clr)
            acc_next = prod;
        else
            acc_next = acc_reg + prod;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> sv/bilinear_sample_with_border_top.sv
// bilinear_sample_with_border_top: bilinear sampler with background border
// depends on bsb_pkg, bsb_ram and bsb_mac
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  command  | start / busy           | func, write_addr, write_data, row_pos, col_pos
//  result   | done (one-cycle strobe)| chan0, chan1, chan2, chan3
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  a store write beat leaves busy low
//  a sample runs two stride products and an address step, then per channel
//  produced four reads and six products, then the done strobe; the steps are
//  serial, set by the shared multiply-accumulate unit and the single store read port
//  done pulses for exactly one cycle; the receiver cannot stall the result
//  reset clears the sequencer and the config registers; the store is not cleared
//  store size must be a power of two so that address wrap is a bit truncation

module bilinear_sample_with_border_top #(
    parameter int STORE_BYTES  = bsb_pkg::STORE_BYTES_DEF,
    parameter int MAX_CHANNELS = bsb_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command beat
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [15:0]                    write_addr,
    input  logic [7:0]                     write_data,
    input  logic signed [31:0]             row_pos,
    input  logic signed [31:0]             col_pos,
    // result beat
    output logic                           done,
    output logic [7:0]                     chan0,
    output logic [7:0]                     chan1,
    output logic [7:0]                     chan2,
    output logic [7:0]                     chan3,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    import bsb_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int ACC_W  = WEIGHT_W + ADDR_W;
    localparam logic [CNT_W-1:0] MAX_CH = CNT_W'(MAX_CHANNELS);

    // configuration registers
    logic [DIM_W-1:0]    rows_reg;
    logic [DIM_W-1:0]    cols_reg;
    logic [STRIDE_W-1:0] rstride_reg;
    logic [STRIDE_W-1:0] cstride_reg;
    logic [CNT_W-1:0]    ccount_reg;
    logic [31:0]         bg_reg;

    // sequencer state
    state_t           state_reg, state_next;
    logic [1:0]       ch_reg, ch_next;
    logic [CNT_W-1:0] nlim_reg, nlim_next;

    // per-sample working registers
    logic [ADDR_W-1:0]   r0_reg, r0_next;
    logic [ADDR_W-1:0]   c0_reg, c0_next;
    logic [FRAC_W-1:0]   dr_reg, dr_next;
    logic [FRAC_W-1:0]   dc_reg, dc_next;
    logic [1:0]          rt_reg, rt_next;
    logic [1:0]          ct_reg, ct_next;
    logic [ADDR_W-1:0]   rowa_reg, rowa_next;   // r0 * row_stride
    logic [ADDR_W-1:0]   rowb_reg, rowb_next;   // (r0+1) * row_stride
    logic [ADDR_W-1:0]   cola_reg, cola_next;   // c0 * col_stride
    logic [ADDR_W-1:0]   colb_reg, colb_next;   // (c0+1) * col_stride
    logic [PIX_W-1:0]    pix_reg  [4];          // p00, p10, p01, p11
    logic [PIX_W-1:0]    pix_next [4];
    logic [PIX_W-1:0]    left_reg, left_next;
    logic [PIX_W-1:0]    right_reg, right_next;
    logic [PIX_W-1:0]    chan_reg  [4];
    logic [PIX_W-1:0]    chan_next [4];

    // shared unit and store
    mac_ctrl_t          mac_ctrl;
    logic [WEIGHT_W-1:0] mac_a;
    logic [ADDR_W-1:0]  mac_b;
    logic [ACC_W-1:0]   mac_acc;
    logic [PIX_W-1:0]   acc_hi;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [PIX_W-1:0]   ram_rdata;

    // decoded command fields
    logic               take;
    logic [31:0]        wa_ext;
    logic [31:0]        r0_ext;
    logic [31:0]        c0_ext;
    logic signed [16:0] r_hi;
    logic signed [16:0] c_hi;
    logic [WEIGHT_W-1:0] ndr;
    logic [WEIGHT_W-1:0] ndc;
    logic [PIX_W-1:0]   bg_byte;
    logic [ADDR_W-1:0]  row_sel;
    logic [ADDR_W-1:0]  col_sel;

    assign take    = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign done    = (state_reg == S_DONE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign wa_ext = {16'b0, write_addr};
    assign r0_ext = {{16{row_pos[31]}}, row_pos[31:16]};
    assign c0_ext = {{16{col_pos[31]}}, col_pos[31:16]};
    assign r_hi   = $signed({row_pos[31], row_pos[31:16]}) + 17'sd1;
    assign c_hi   = $signed({col_pos[31], col_pos[31:16]}) + 17'sd1;

    assign ndr     = WEIGHT_ONE - {1'b0, dr_reg};
    assign ndc     = WEIGHT_ONE - {1'b0, dc_reg};
    assign bg_byte = bg_reg[8*ch_reg +: 8];
    assign acc_hi  = mac_acc[FRAC_W +: PIX_W];

    // store write straight from the command beat
    assign ram_we    = take && !func;
    assign ram_waddr = wa_ext[ADDR_W-1:0];
    assign ram_raddr = row_sel + col_sel + ADDR_W'(ch_reg);

    bsb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (write_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsb_mac #(
        .A_W (WEIGHT_W),
        .B_W (ADDR_W)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (mac_acc)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= 13'd1;
            cols_reg    <= 13'd1;
            rstride_reg <= '0;
            cstride_reg <= '0;
            ccount_reg  <= 3'd1;
            bg_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_ROWS: rows_reg    <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_COLS: cols_reg    <= cfg_data[DIM_W-1:0];
                CFG_ROW_STRIDE: rstride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_COL_STRIDE: cstride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_CHAN_COUNT: ccount_reg  <= cfg_data[CNT_W-1:0];
                CFG_BACKGROUND: bg_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // read address: row base and column base of the neighbour being fetched
    always_comb
    begin
        case (state_reg)
            S_RD10:  begin row_sel = rowb_reg; col_sel = cola_reg; end
            S_RD01:  begin row_sel = rowa_reg; col_sel = colb_reg; end
            S_RD11:  begin row_sel = rowb_reg; col_sel = colb_reg; end
            default: begin row_sel = rowa_reg; col_sel = cola_reg; end
        endcase
    end

    // sequencer: next state, working registers and shared unit control
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        nlim_next  = nlim_reg;
        r0_next    = r0_reg;
        c0_next    = c0_reg;
        dr_next    = dr_reg;
        dc_next    = dc_reg;
        rt_next    = rt_reg;
        ct_next    = ct_reg;
        rowa_next  = rowa_reg;
        rowb_next  = rowb_reg;
        cola_next  = cola_reg;
        colb_next  = colb_reg;
        left_next  = left_reg;
        right_next = right_reg;
        for (int i = 0; i < 4; i++)
        begin
            pix_next[i]  = pix_reg[i];
            chan_next[i] = chan_reg[i];
        end
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (take && func)
                begin
                    state_next = S_ROWMUL;
                    ch_next    = '0;
                    nlim_next  = (chan_limit(ccount_reg) < MAX_CH) ?
                                 chan_limit(ccount_reg) : MAX_CH;
                    r0_next    = r0_ext[ADDR_W-1:0];
                    c0_next    = c0_ext[ADDR_W-1:0];
                    dr_next    = row_pos[FRAC_W-1:0];
                    dc_next    = col_pos[FRAC_W-1:0];
                    rt_next    = lines_taken(r_hi, rows_reg);
                    ct_next    = lines_taken(c_hi, cols_reg);
                    for (int i = 0; i < 4; i++)
                    begin
                        chan_next[i] = '0;
                    end
                end
            end
            S_ROWMUL:
            begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b1};
                mac_a      = {1'b0, rstride_reg};
                mac_b      = r0_reg;
                state_next = S_COLMUL;
            end
            S_COLMUL:
            begin
                rowa_next  = mac_acc[ADDR_W-1:0];
                mac_ctrl   = '{en: 1'b1, clr: 1'b1};
                mac_a      = {1'b0, cstride_reg};
                mac_b      = c0_reg;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                rowb_next  = rowa_reg + ADDR_W'(rstride_reg);
                cola_next  = mac_acc[ADDR_W-1:0];
                colb_next  = mac_acc[ADDR_W-1:0] + ADDR_W'(cstride_reg);
                state_next = (nlim_reg == '0) ? S_DONE : S_RD00;
            end
            S_RD00:
            begin
                state_next = S_RD10;
            end
            S_RD10:
            begin
                pix_next[0] = (rt_reg[0] && ct_reg[0]) ? ram_rdata : bg_byte;
                state_next  = S_RD01;
            end
            S_RD01:
            begin
                pix_next[1] = (rt_reg[1] && ct_reg[0]) ? ram_rdata : bg_byte;
                state_next  = S_RD11;
            end
            S_RD11:
            begin
                pix_next[2] = (rt_reg[0] && ct_reg[1]) ? ram_rdata : bg_byte;
                state_next  = S_M0;
            end
            S_M0:
            begin
                pix_next[3] = (rt_reg[1] && ct_reg[1]) ? ram_rdata : bg_byte;
                mac_ctrl    = '{en: 1'b1, clr: 1'b1};
                mac_a       = ndr;
                mac_b       = ADDR_W'(pix_reg[0]);
                state_next  = S_M1;
            end
            S_M1:
            begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0};
                mac_a      = {1'b0, dr_reg};
                mac_b      = ADDR_W'(pix_reg[1]);
                state_next = S_M2;
            end
            S_M2:
            begin
                left_next  = acc_hi;
                mac_ctrl   = '{en: 1'b1, clr: 1'b1};
                mac_a      = ndr;
                mac_b      = ADDR_W'(pix_reg[2]);
                state_next = S_M3;
            end
            S_M3:
            begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0};
                mac_a      = {1'b0, dr_reg};
                mac_b      = ADDR_W'(pix_reg[3]);
                state_next = S_M4;
            end
            S_M4:
            begin
                right_next = acc_hi;
                mac_ctrl   = '{en: 1'b1, clr: 1'b1};
                mac_a      = ndc;
                mac_b      = ADDR_W'(left_reg);
                state_next = S_M5;
            end
            S_M5:
            begin
                mac_ctrl   = '{en: 1'b1, clr: 1'b0};
                mac_a      = {1'b0, dc_reg};
                mac_b      = ADDR_W'(right_reg);
                state_next = S_M6;
            end
            S_M6:
            begin
                chan_next[ch_reg] = acc_hi;
                if (({1'b0, ch_reg} + 3'd1) < nlim_reg)
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_RD00;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            nlim_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            nlim_reg  <= nlim_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        r0_reg    <= r0_next;
        c0_reg    <= c0_next;
        dr_reg    <= dr_next;
        dc_reg    <= dc_next;
        rt_reg    <= rt_next;
        ct_reg    <= ct_next;
        rowa_reg  <= rowa_next;
        rowb_reg  <= rowb_next;
        cola_reg  <= cola_next;
        colb_reg  <= colb_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        for (int i = 0; i < 4; i++)
        begin
            pix_reg[i]  <= pix_next[i];
            chan_reg[i] <= chan_next[i];
        end
    end

    assign chan0 = chan_reg[0];
    assign chan1 = chan_reg[1];
    assign chan2 = chan_reg[2];
    assign chan3 = chan_reg[3];

    // a sample beat makes the block busy, a store write beat does not
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func) |=> busy)
        else $error("sample beat did not start the sequencer");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func) |=> !busy)
        else $error("store write beat left the block busy");

    // the result strobe lasts one cycle and returns the block to idle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // channel 3 reads zero under a channel count below four, and channels 0 to 2 when none are produced
    a_chan3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ccount_reg[2]) |-> (chan3 == '0))
        else $error("unused channel 3 not zero");

    a_no_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (ccount_reg == 3'd0 || ccount_reg == 3'd2)) |->
        (chan0 == '0 && chan1 == '0 && chan2 == '0))
        else $error("channel count without output gave data");

endmodule

>>> test/bsb_tb_pkg.sv
`timescale 1ns / 100ps
// bsb_tb_pkg: command codes, result type and the scoreboard class of the sampler testbench
// depends on bsb_pkg for the configuration register indexes

package bsb_tb_pkg;

    localparam logic FN_WRITE   = 1'b0;
    localparam logic FN_SAMPLE  = 1'b1;
    localparam int   STORE_SIZE = 65536;

    // chan3..chan0, channel c in byte c
    typedef logic [3:0][7:0] pixel_quad_t;

    class sampler_scoreboard;
        logic [7:0]  image_bytes [STORE_SIZE];
        bit          byte_written [STORE_SIZE];
        logic [12:0] rows;
        logic [12:0] cols;
        logic [15:0] row_step;
        logic [15:0] col_step;
        logic [2:0]  chan_cfg;
        logic [31:0] background;
        pixel_quad_t pending_pixels [$];
        logic [15:0] reads [$];
        int          errors;
        int          writes_seen;
        int          samples_seen;
        int          edge_samples;
        int          results_matched;

        function new();
            rows            = 13'd1;
            cols            = 13'd1;
            row_step        = 16'd0;
            col_step        = 16'd0;
            chan_cfg        = 3'd1;
            background      = 32'd0;
            errors          = 0;
            writes_seen     = 0;
            samples_seen    = 0;
            edge_samples    = 0;
            results_matched = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                bsb_pkg::CFG_IMAGE_ROWS: rows       = data[12:0];
                bsb_pkg::CFG_IMAGE_COLS: cols       = data[12:0];
                bsb_pkg::CFG_ROW_STRIDE: row_step   = data[15:0];
                bsb_pkg::CFG_COL_STRIDE: col_step   = data[15:0];
                bsb_pkg::CFG_CHAN_COUNT: chan_cfg   = data[2:0];
                bsb_pkg::CFG_BACKGROUND: background = data;
                default: ;
            endcase
        endfunction

        function int channels_out();
            if (chan_cfg == 3'd1)
                return 1;
            if (chan_cfg == 3'd3)
                return 3;
            if (chan_cfg >= 3'd4)
                return 4;
            return 0;
        endfunction

        // bit0: lower line inside, bit1: upper line inside
        function logic [1:0] lines_in(longint hi, longint dim);
            if (hi > 0 && hi < dim)
                return 2'b11;
            if (hi == 0)
                return 2'b10;
            if (hi == dim)
                return 2'b01;
            return 2'b00;
        endfunction

        // 64-bit wrap, then truncation to the store size
        function logic [15:0] byte_addr(longint r, longint c, int ch);
            longint unsigned a;
            a = longint'(r) * longint'({48'd0, row_step})
              + longint'(c) * longint'({48'd0, col_step}) + longint'(ch);
            return a[15:0];
        endfunction

        // store bytes a sample at this position reads
        function void collect_reads(logic signed [31:0] rpos, logic signed [31:0] cpos);
            longint     r0;
            longint     c0;
            logic [1:0] rt;
            logic [1:0] ct;
            reads.delete();
            r0 = longint'(rpos >>> 16);
            c0 = longint'(cpos >>> 16);
            rt = lines_in(r0 + 1, longint'(rows));
            ct = lines_in(c0 + 1, longint'(cols));
            for (int ch = 0; ch < channels_out(); ch++)
                for (int dy = 0; dy < 2; dy++)
                    for (int dx = 0; dx < 2; dx++)
                        if (rt[dy] && ct[dx])
                            reads.push_back(byte_addr(r0 + dy, c0 + dx, ch));
        endfunction

        function pixel_quad_t blend_at(logic signed [31:0] rpos, logic signed [31:0] cpos);
            longint            r0;
            longint            c0;
            longint unsigned   dr;
            longint unsigned   dc;
            longint unsigned   ndr;
            longint unsigned   ndc;
            longint unsigned   p [2][2];
            longint unsigned   left;
            longint unsigned   right;
            longint unsigned   v;
            logic [1:0]        rt;
            logic [1:0]        ct;
            pixel_quad_t       q;
            r0  = longint'(rpos >>> 16);
            c0  = longint'(cpos >>> 16);
            dr  = longint'(rpos[15:0]);
            dc  = longint'(cpos[15:0]);
            ndr = 64'h10000 - dr;
            ndc = 64'h10000 - dc;
            rt  = lines_in(r0 + 1, longint'(rows));
            ct  = lines_in(c0 + 1, longint'(cols));
            if (channels_out() > 0 && (rt != 2'b11 || ct != 2'b11))
                edge_samples++;
            q = '0;
            for (int ch = 0; ch < 4; ch++)
            begin
                if (ch < channels_out())
                begin
                    for (int dy = 0; dy < 2; dy++)
                        for (int dx = 0; dx < 2; dx++)
                            if (rt[dy] && ct[dx])
                                p[dy][dx] = 64'(image_bytes[byte_addr(r0 + dy, c0 + dx, ch)]);
                            else
                                p[dy][dx] = 64'(background[8*ch +: 8]);
                    left  = (p[1][0] * dr + p[0][0] * ndr) >> 16;
                    right = (p[1][1] * dr + p[0][1] * ndr) >> 16;
                    v     = (ndc * left + dc * right) >> 16;
                    q[ch] = v[7:0];
                end
            end
            return q;
        endfunction

        function void note_command(logic fn, logic [15:0] waddr, logic [7:0] wdata,
                                   logic signed [31:0] rpos, logic signed [31:0] cpos);
            if (fn == FN_WRITE)
            begin
                image_bytes[waddr]  = wdata;
                byte_written[waddr] = 1'b1;
                writes_seen++;
            end
            else
            begin
                pending_pixels.push_back(blend_at(rpos, cpos));
                samples_seen++;
            end
        endfunction

        function void check_result(pixel_quad_t got);
            pixel_quad_t want;
            bit          clean;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: result %h with no sample outstanding", $time, got);
                errors++;
                return;
            end
            want  = pending_pixels.pop_front();
            clean = 1'b1;
            for (int ch = 0; ch < 4; ch++)
            begin
                if (got[ch] !== want[ch])
                begin
                    $display("%0t: chan%0d expected %02h actual %02h",
                             $time, ch, want[ch], got[ch]);
                    errors++;
                    clean = 1'b0;
                end
            end
            if (clean)
                results_matched++;
        endfunction
    endclass

endpackage

>>> test/testbench.sv
`timescale 1ns / 100ps
// testbench: random and directed store writes and samples for the bilinear sampler,
// each result checked against a predictor in the scoreboard class
// depends on bsb_pkg, bsb_tb_pkg and bilinear_sample_with_border_top

module testbench;
    import bsb_tb_pkg::*;

    localparam int ITEM_TARGET  = 1450;
    localparam int PHASE_BEATS  = 110;
    // longer than a four-channel sample takes, so this covers any sample still in flight
    localparam int DRAIN_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic [15:0]        write_addr;
    logic [7:0]         write_data;
    logic signed [31:0] row_pos;
    logic signed [31:0] col_pos;
    logic               done;
    logic [7:0]         chan0;
    logic [7:0]         chan1;
    logic [7:0]         chan2;
    logic [7:0]         chan3;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    sampler_scoreboard  board;
    int                 beats_sent;
    int                 settings_used;
    bit                 calm;           // phase with back-to-back command beats

    bilinear_sample_with_border_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .write_addr (write_addr),
        .write_data (write_data),
        .row_pos    (row_pos),
        .col_pos    (col_pos),
        .done       (done),
        .chan0      (chan0),
        .chan1      (chan1),
        .chan2      (chan2),
        .chan3      (chan3),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results cannot be held off, so every strobe is taken at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result({chan3, chan2, chan1, chan0});
    end

    // a slowest legal run is under a million ns, so this only trips on a hang
    initial
    begin
        #(5_000_000);
        $display("%0t: run timed out, %0d samples outstanding",
                 $time, board.pending_pixels.size());
        $display("== FAIL ==");
        $finish;
    end

    // drop start so no beat is offered while the stimulus waits
    task automatic hold_off();
        @(negedge clk);
        start = 1'b0;
    endtask

    // one command beat: a random gap outside calm phases, then start held until busy is seen low
    task automatic send_beat(input logic fn, input logic [15:0] addr, input logic [7:0] data,
                             input logic [31:0] rp, input logic [31:0] cp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      = 1'b1;
        func       = fn;
        write_addr = addr;
        write_data = data;
        row_pos    = rp;
        col_pos    = cp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(fn, addr, data, rp, cp);
        beats_sent++;
    endtask

    // sample beat, preceded by writes to any store byte it would read unwritten
    task automatic sample_at(input logic [31:0] rp, input logic [31:0] cp);
        logic [15:0] need [$];
        board.collect_reads(rp, cp);
        need = board.reads;
        foreach (need[i])
            if (!board.byte_written[need[i]])
                send_beat(FN_WRITE, need[i], 8'($urandom), $urandom, $urandom);
        send_beat(FN_SAMPLE, 16'($urandom), 8'($urandom), rp, cp);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_setting(input logic [12:0] nr, input logic [12:0] nc,
                                 input logic [15:0] rs, input logic [15:0] cs,
                                 input logic [2:0] ch, input logic [31:0] bg);
        write_reg(bsb_pkg::CFG_IMAGE_ROWS, {19'd0, nr});
        write_reg(bsb_pkg::CFG_IMAGE_COLS, {19'd0, nc});
        write_reg(bsb_pkg::CFG_ROW_STRIDE, {16'd0, rs});
        write_reg(bsb_pkg::CFG_COL_STRIDE, {16'd0, cs});
        write_reg(bsb_pkg::CFG_CHAN_COUNT, {29'd0, ch});
        write_reg(bsb_pkg::CFG_BACKGROUND, bg);
        settings_used++;
    endtask

    // wait for every outstanding sample, then for the sequencer to go quiet
    task automatic settle();
        hold_off();
        while (board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // 16.16 position: mostly around the image and its borders, sometimes anywhere
    function automatic logic [31:0] pick_pos(input int dim);
        int          whole;
        int unsigned mode;
        logic [15:0] frac;
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
            0:       frac = 16'h0000;
            1:       frac = 16'hFFFF;
            default: frac = 16'($urandom);
        endcase
        if (mode < 2)
            whole = $urandom;
        else if (mode < 5)
        begin
            case ($urandom_range(0, 5))
                0:       whole = -2;
                1:       whole = -1;
                2:       whole = 0;
                3:       whole = dim - 2;
                4:       whole = dim - 1;
                default: whole = dim;
            endcase
        end
        else
            whole = int'($urandom_range(0, dim)) - 1;
        return {whole[15:0], frac};
    endfunction

    initial
    begin
        logic [12:0] nr;
        logic [12:0] nc;
        logic [15:0] rs;
        logic [15:0] cs;
        logic [2:0]  ch;
        logic [31:0] bg;
        int          phase;
        int          phase_end;

        board         = new();
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FN_WRITE;
        write_addr    = 16'd0;
        write_data    = 8'd0;
        row_pos       = 32'sd0;
        col_pos       = 32'sd0;
        cfg_valid     = 1'b0;
        cfg_index     = bsb_pkg::CFG_IMAGE_ROWS;
        cfg_data      = 32'd0;
        beats_sent    = 0;
        settings_used = 0;
        calm          = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: a 2x2 single channel image at bytes 0..3, background a5
        write_setting(13'd2, 13'd2, 16'd2, 16'd1, 3'd1, 32'h0000_00A5);
        send_beat(FN_WRITE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(FN_WRITE, 16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_beat(FN_WRITE, 16'h0001, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(FN_WRITE, 16'h0002, 8'h80, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(FN_WRITE, 16'h0003, 8'h3C, 32'h5555_AAAA, 32'hAAAA_5555);
        sample_at(32'h0000_0000, 32'h0000_0000);     // exact top-left pixel
        sample_at(32'h0000_8000, 32'h0000_8000);     // centre of the four
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);     // largest fractions
        sample_at(32'hFFFF_4000, 32'h0000_4000);     // above: only the lower row inside
        sample_at(32'h0001_8000, 32'h0000_C000);     // below: only the upper row inside
        sample_at(32'h0000_2000, 32'hFFFF_E000);     // left of the image
        sample_at(32'h0000_6000, 32'h0001_1000);     // right of the image
        sample_at(32'hFFFF_C000, 32'h0001_C000);     // diagonal corner, one pixel inside
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);     // far outside both ways
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(32'hFFFE_0000, 32'h0000_0000);     // two rows above: all background

        // random phases, each under a fresh register setting
        phase = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            settle();
            case (phase)
                0:
                begin
                    // sizes of 4096, largest strides, channel count beyond four
                    nr = 13'd4096; nc = 13'd4096; rs = 16'hFFFF; cs = 16'hFFFF;
                    ch = 3'd7; bg = 32'hFFFF_FFFF;
                end
                1:
                begin
                    // smallest setting, everything folds onto one byte
                    nr = 13'd1; nc = 13'd1; rs = 16'd0; cs = 16'd0;
                    ch = 3'd1; bg = 32'd0;
                end
                2:
                begin
                    // zero-sized image: the upper line wins at index zero
                    nr = 13'd0; nc = 13'd0; rs = 16'd12; cs = 16'd3;
                    ch = 3'd3; bg = $urandom;
                end
                3:
                begin
                    // no channels produced, all zero results
                    nr = 13'd3; nc = 13'd5; rs = 16'd20; cs = 16'd4;
                    ch = 3'd0; bg = $urandom;
                end
                4:
                begin
                    // two channels also gives zeros
                    nr = 13'd6; nc = 13'd2; rs = 16'd8; cs = 16'd4;
                    ch = 3'd2; bg = $urandom;
                end
                5:
                begin
                    // tall single column image
                    nr = 13'd4096; nc = 13'd1; rs = 16'd4; cs = 16'd4;
                    ch = 3'd4; bg = $urandom;
                end
                default:
                begin
                    nr = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096))
                                                     : 13'($urandom_range(1, 8));
                    nc = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096))
                                                     : 13'($urandom_range(1, 8));
                    case ($urandom_range(0, 9))
                        0, 1, 2: ch = 3'd1;
                        3, 4, 5: ch = 3'd3;
                        6, 7, 8: ch = 3'd4;
                        default: ch = 3'($urandom_range(0, 7));
                    endcase
                    cs = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 5));
                    rs = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(nc * cs);
                    bg = $urandom;
                end
            endcase
            write_setting(nr, nc, rs, cs, ch, bg);
            calm      = ($urandom_range(0, 3) == 0);
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    // stray write anywhere in the store
                    send_beat(FN_WRITE, 16'($urandom), 8'($urandom), $urandom, $urandom);
                else
                    sample_at(pick_pos(int'(nr)), pick_pos(int'(nc)));
                if ($urandom_range(0, 39) == 0)
                begin
                    // hold back until every sample has come out
                    hold_off();
                    while (board.pending_pixels.size() != 0)
                        @(posedge clk);
                end
            end
            phase++;
        end

        settle();
        $display("covered %0d store writes and %0d samples under %0d register settings",
                 board.writes_seen, board.samples_seen, settings_used);
        $display("%0d samples reached the border, %0d results matched, %0d mismatches",
                 board.edge_samples, board.results_matched, board.errors);
        if (board.errors == 0 && board.pending_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
